FILE: src/vsf_pkg.sv
// ----------------------------------------------------------------------------
// vsf_pkg
// shared widths, codes and types of the vertical seam finder
// ----------------------------------------------------------------------------
package vsf_pkg;

   localparam int ENERGY_W  = 16;
   localparam int COST_W    = 32;
   localparam int CFG_W     = 10;
   localparam int PORT_W    = 9;
   localparam int CFG_IDX_W = 1;

   localparam logic [COST_W-1:0] COST_INF  = '1;
   localparam logic [CFG_W-1:0]  CFG_RESET = 10'd512;

   localparam logic [1:0] CH_CENTRE = 2'd0;
   localparam logic [1:0] CH_LEFT   = 2'd1;
   localparam logic [1:0] CH_RIGHT  = 2'd2;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
   localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

   typedef logic [1:0] choice_type;

   typedef struct packed {
      logic first_row;
      logic has_left;
      logic has_right;
   } step_ctl_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      choice_type        choice;
   } step_type;

endpackage

FILE: src/vsf_ram.sv
// ----------------------------------------------------------------------------
// vsf_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module vsf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/vsf_dp_step.sv
// ----------------------------------------------------------------------------
// vsf_dp_step
// cumulative cost of one pixel: best upper neighbor plus energy, saturating
// ----------------------------------------------------------------------------
module vsf_dp_step import vsf_pkg::*; (
   input  step_ctl_type        ctl,
   input  logic [COST_W-1:0]   up_left,
   input  logic [COST_W-1:0]   up_center,
   input  logic [COST_W-1:0]   up_right,
   input  logic [ENERGY_W-1:0] energy,
   output step_type            result
);

   logic [COST_W-1:0] best;
   choice_type        choice;
   logic [COST_W:0]   sum;

   always_comb begin
      best   = up_center;
      choice = CH_CENTRE;
      if (ctl.has_left && (up_left < best)) begin
         best   = up_left;
         choice = CH_LEFT;
      end
      if (ctl.has_right && (up_right < best)) begin
         best   = up_right;
         choice = CH_RIGHT;
      end
      sum = {1'b0, best} + (COST_W + 1)'(energy);
      if (ctl.first_row) begin
         result.cost   = COST_W'(energy);
         result.choice = CH_CENTRE;
      end else begin
         result.cost   = sum[COST_W] ? COST_INF : sum[COST_W-1:0];
         result.choice = choice;
      end
   end

endmodule

FILE: src/vertical_seam_finder_core.sv
// ----------------------------------------------------------------------------
// vertical_seam_finder_core
// load word: cost-row memory read on accept, then update and write back
// read word: seam store read, response registered once the output is free
// last pixel of frame: bottom-up seam trace, one choice read per row but row 0
// reset: all MAX_HEIGHT seam store rows cleared, no word accepted meanwhile
// ----------------------------------------------------------------------------
module vertical_seam_finder_core import vsf_pkg::*; #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [ENERGY_W-1:0]  req_energy,
   input  logic [PORT_W-1:0]    req_row_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PORT_W-1:0]    rsp_seam_row,
   output logic [PORT_W-1:0]    rsp_seam_column,
   output logic                 rsp_seam_ready,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int EXT_A = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int EXT_B = (RW + 1 > PORT_W) ? RW + 1 : PORT_W;
   localparam int EXT_W = (EXT_A > EXT_B) ? EXT_A : EXT_B;
   localparam int CHOICE_DEPTH = MAX_HEIGHT * (2 ** CW);

   localparam logic [EXT_W-1:0] MAXW_X = EXT_W'(MAX_WIDTH);
   localparam logic [EXT_W-1:0] MAXH_X = EXT_W'(MAX_HEIGHT);
   localparam logic [RW-1:0]    LAST_CLR = RW'(MAX_HEIGHT - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_PIXEL  = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_TRACE0 = 3'd4;
   localparam logic [2:0] ST_TRACE  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CFG_W-1:0]    width_cfg_ff, width_cfg_in;
   logic [CFG_W-1:0]    height_cfg_ff, height_cfg_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic                parity_ff, parity_in;
   logic [COST_W-1:0]   bot_cost_ff, bot_cost_in;
   logic [CW-1:0]       bot_col_ff, bot_col_in;
   logic                frame_done_ff, frame_done_in;
   logic [RW-1:0]       clr_addr_ff, clr_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [COST_W-1:0]   left_ff, left_in;
   logic [COST_W-1:0]   center_ff, center_in;
   logic [COST_W-1:0]   col0_cost_ff, col0_cost_in;
   logic [RW-1:0]       trace_row_ff, trace_row_in;
   logic [CW-1:0]       trace_col_ff, trace_col_in;
   logic [PORT_W-1:0]   rd_row_ff, rd_row_in;
   logic                rd_hit_ff, rd_hit_in;
   logic [PORT_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [PORT_W-1:0]   rsp_col_ff, rsp_col_in;
   logic                rsp_hit_ff, rsp_hit_in;

   logic [EXT_W-1:0]    w_x, h_x;
   logic [CW:0]         w_eff, col_next;
   logic [RW:0]         h_eff, row_next;
   logic                has_right, last_row, bot_take;
   logic [CW-1:0]       bot_col_new, new_col;
   logic [RW-1:0]       trace_row_m1;
   logic                req_fire;

   logic                cost_rd_en, pix_we;
   logic [COST_W-1:0]   cost0_rd, cost1_rd, prev_rd;
   logic                choice_we, choice_rd_en;
   logic [RW+CW-1:0]    choice_wr_addr, choice_rd_addr;
   choice_type          choice_rd;
   logic                seam_we, seam_rd_en;
   logic [RW-1:0]       seam_wr_addr;
   logic [CW-1:0]       seam_wr_data, seam_rd;

   step_ctl_type        step_ctl;
   step_type            step;

   // effective frame size
   always_comb begin
      w_x = EXT_W'(width_cfg_ff);
      h_x = EXT_W'(height_cfg_ff);
      if (w_x == '0) begin
         w_eff = (CW + 1)'(1);
      end else if (w_x > MAXW_X) begin
         w_eff = (CW + 1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW + 1)'(width_cfg_ff);
      end
      if (h_x == '0) begin
         h_eff = (RW + 1)'(1);
      end else if (h_x > MAXH_X) begin
         h_eff = (RW + 1)'(MAX_HEIGHT);
      end else begin
         h_eff = (RW + 1)'(height_cfg_ff);
      end
   end

   assign col_next  = {1'b0, col_ff} + (CW + 1)'(1);
   assign row_next  = {1'b0, row_ff} + (RW + 1)'(1);
   assign has_right = (col_next < w_eff);
   assign last_row  = !(row_next < h_eff);
   assign prev_rd   = parity_ff ? cost0_rd : cost1_rd;

   assign step_ctl.first_row = (row_ff == '0);
   assign step_ctl.has_left  = (col_ff != '0);
   assign step_ctl.has_right = has_right;

   vsf_dp_step u_dp_step (
      .ctl       (step_ctl),
      .up_left   (left_ff),
      .up_center (center_ff),
      .up_right  (prev_rd),
      .energy    (energy_ff),
      .result    (step)
   );

   assign bot_take    = last_row && ((col_ff == '0) || (step.cost < bot_cost_ff));
   assign bot_col_new = bot_take ? col_ff : bot_col_ff;

   // one step up the seam
   always_comb begin
      case (choice_rd)
         CH_LEFT:  new_col = trace_col_ff - CW'(1);
         CH_RIGHT: new_col = trace_col_ff + CW'(1);
         default:  new_col = trace_col_ff;
      endcase
   end

   assign trace_row_m1 = trace_row_ff - RW'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      parity_in     = parity_ff;
      bot_cost_in   = bot_cost_ff;
      bot_col_in    = bot_col_ff;
      frame_done_in = frame_done_ff;
      clr_addr_in   = clr_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      energy_in     = energy_ff;
      left_in       = left_ff;
      center_in     = center_ff;
      col0_cost_in  = col0_cost_ff;
      trace_row_in  = trace_row_ff;
      trace_col_in  = trace_col_ff;
      rd_row_in     = rd_row_ff;
      rd_hit_in     = rd_hit_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_hit_in    = rsp_hit_ff;

      cost_rd_en     = 1'b0;
      pix_we         = 1'b0;
      choice_we      = 1'b0;
      choice_wr_addr = {row_ff, col_ff};
      choice_rd_en   = 1'b0;
      choice_rd_addr = {trace_row_ff, trace_col_ff};
      seam_we        = 1'b0;
      seam_wr_addr   = trace_row_ff;
      seam_wr_data   = trace_col_ff;
      seam_rd_en     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            seam_we      = 1'b1;
            seam_wr_addr = clr_addr_ff;
            seam_wr_data = '0;
            clr_addr_in  = clr_addr_ff + RW'(1);
            if (clr_addr_ff == LAST_CLR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_LOAD) begin
                  cost_rd_en = 1'b1;
                  energy_in  = req_energy;
                  state_in   = ST_PIXEL;
               end else begin
                  seam_rd_en = 1'b1;
                  rd_row_in  = req_row_index;
                  rd_hit_in  = frame_done_ff && (EXT_W'(req_row_index) < EXT_W'(h_eff));
                  state_in   = ST_READ;
               end
            end
         end
         ST_PIXEL: begin
            pix_we    = 1'b1;
            choice_we = 1'b1;
            if (bot_take) begin
               bot_cost_in = step.cost;
               bot_col_in  = col_ff;
            end
            if (col_ff == '0) begin
               col0_cost_in = step.cost;
            end
            if (has_right) begin
               col_in    = col_next[CW-1:0];
               left_in   = center_ff;
               center_in = prev_rd;
               state_in  = ST_IDLE;
            end else begin
               col_in    = '0;
               parity_in = !parity_ff;
               center_in = (col_ff == '0) ? step.cost : col0_cost_ff;
               if (!last_row) begin
                  row_in   = row_next[RW-1:0];
                  state_in = ST_IDLE;
               end else begin
                  trace_row_in = row_ff;
                  trace_col_in = bot_col_new;
                  row_in       = '0;
                  parity_in    = 1'b0;
                  bot_cost_in  = COST_INF;
                  bot_col_in   = '0;
                  state_in     = ST_TRACE0;
               end
            end
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = rd_row_ff;
               rsp_col_in   = rd_hit_ff ? PORT_W'(seam_rd) : '0;
               rsp_hit_in   = rd_hit_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_TRACE0: begin
            seam_we = 1'b1;
            if (trace_row_ff == '0) begin
               frame_done_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               choice_rd_en = 1'b1;
               state_in     = ST_TRACE;
            end
         end
         ST_TRACE: begin
            seam_we        = 1'b1;
            seam_wr_addr   = trace_row_m1;
            seam_wr_data   = new_col;
            trace_row_in   = trace_row_m1;
            trace_col_in   = new_col;
            choice_rd_addr = {trace_row_m1, new_col};
            if (trace_row_m1 == '0) begin
               frame_done_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               choice_rd_en = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register write restarts the frame being loaded
      if (csr_we) begin
         case (csr_index)
            REG_WIDTH:  width_cfg_in  = csr_wdata;
            REG_HEIGHT: height_cfg_in = csr_wdata;
            default: begin
            end
         endcase
         if ((csr_index == REG_WIDTH) || (csr_index == REG_HEIGHT)) begin
            col_in      = '0;
            row_in      = '0;
            parity_in   = 1'b0;
            bot_cost_in = COST_INF;
            bot_col_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         width_cfg_ff  <= CFG_RESET;
         height_cfg_ff <= CFG_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         parity_ff     <= 1'b0;
         bot_cost_ff   <= COST_INF;
         bot_col_ff    <= '0;
         frame_done_ff <= 1'b0;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         parity_ff     <= parity_in;
         bot_cost_ff   <= bot_cost_in;
         bot_col_ff    <= bot_col_in;
         frame_done_ff <= frame_done_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      energy_ff    <= energy_in;
      left_ff      <= left_in;
      center_ff    <= center_in;
      col0_cost_ff <= col0_cost_in;
      trace_row_ff <= trace_row_in;
      trace_col_ff <= trace_col_in;
      rd_row_ff    <= rd_row_in;
      rd_hit_ff    <= rd_hit_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   // cost rows, ping-pong by row parity
   vsf_ram #(.WIDTH(COST_W), .DEPTH(MAX_WIDTH)) u_cost_bank0 (
      .clock   (clock),
      .wr_en   (pix_we && !parity_ff),
      .wr_addr (col_ff),
      .wr_data (step.cost),
      .rd_en   (cost_rd_en),
      .rd_addr (col_next[CW-1:0]),
      .rd_data (cost0_rd)
   );

   vsf_ram #(.WIDTH(COST_W), .DEPTH(MAX_WIDTH)) u_cost_bank1 (
      .clock   (clock),
      .wr_en   (pix_we && parity_ff),
      .wr_addr (col_ff),
      .wr_data (step.cost),
      .rd_en   (cost_rd_en),
      .rd_addr (col_next[CW-1:0]),
      .rd_data (cost1_rd)
   );

   vsf_ram #(.WIDTH(2), .DEPTH(CHOICE_DEPTH)) u_choice_store (
      .clock   (clock),
      .wr_en   (choice_we),
      .wr_addr (choice_wr_addr),
      .wr_data (step.choice),
      .rd_en   (choice_rd_en),
      .rd_addr (choice_rd_addr),
      .rd_data (choice_rd)
   );

   vsf_ram #(.WIDTH(CW), .DEPTH(MAX_HEIGHT)) u_seam_store (
      .clock   (clock),
      .wr_en   (seam_we),
      .wr_addr (seam_wr_addr),
      .wr_data (seam_wr_data),
      .rd_en   (seam_rd_en),
      .rd_addr (RW'(req_row_index)),
      .rd_data (seam_rd)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seam_row    = rsp_row_ff;
   assign rsp_seam_column = rsp_col_ff;
   assign rsp_seam_ready  = rsp_hit_ff;

endmodule

FILE: src/vsf_checker.sv
// ----------------------------------------------------------------------------
// vsf_checker
// port-level checks of the vertical seam finder, bound to the top level
// ----------------------------------------------------------------------------
module vsf_checker import vsf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_mode,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [PORT_W-1:0] rsp_seam_row,
   input logic [PORT_W-1:0] rsp_seam_column,
   input logic              rsp_seam_ready
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seam_row)
         && $stable(rsp_seam_column) && $stable(rsp_seam_ready))
      else $error("stalled response word changed");

   // no seam means column zero
   a_not_ready_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_seam_ready |-> rsp_seam_column == '0)
      else $error("column nonzero without seam");

   // a read word occupies the block for its memory cycle
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_READ) |=> !req_ready)
      else $error("input taken during seam read");

   // seam store clear follows reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input taken during clear");

   // a rising response only follows a busy block
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response word without read");

endmodule

bind vertical_seam_finder_core vsf_checker u_vsf_checker (.*);
